FILE: rtl/hrkd_pkg.sv
// Shared types and constants for the HID report key event differ.
// Used by hrkd_evq and hid_report_key_event_diff. No dependencies.
package hrkd_pkg;

  localparam int KeySlots     = 6;
  localparam int KeyW         = 8;
  localparam int KeycodeSpace = 1 << KeyW;
  localparam int SlotW        = $clog2(KeySlots);
  localparam int StW          = 2;

  // Per-keycode status: bit 0 held, bit 1 seen again in this report.
  localparam logic [StW-1:0] StIdle = 2'b00;
  localparam logic [StW-1:0] StHeld = 2'b01;
  localparam logic [StW-1:0] StSeen = 2'b10;

  localparam int MaxEvents = 2 * KeySlots;

  // Event queue; the depth must stay a power of two (pointers wrap freely).
  localparam int EvqDepth = 16;
  localparam int EvqPtrW  = $clog2(EvqDepth);
  localparam int EvqCntW  = EvqPtrW + 1;

  typedef struct packed {
    logic [KeyW-1:0] keycode;
    logic [KeyW-1:0] modifiers;
    logic            is_press;
    logic            last;
  } event_t;

endpackage

FILE: rtl/hrkd_evq.sv
// Event queue: small register FIFO between the status engine and the output port.
// Depends on hrkd_pkg.
module hrkd_evq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  hrkd_pkg::event_t              push_ev_i,
  output logic [hrkd_pkg::EvqCntW-1:0]  cnt_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hrkd_pkg::event_t              out_ev_o
);

  hrkd_pkg::event_t                 evq_mem [hrkd_pkg::EvqDepth];
  logic [hrkd_pkg::EvqPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [hrkd_pkg::EvqPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [hrkd_pkg::EvqCntW-1:0]     cnt_q, cnt_d;
  logic                             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_ev_o    = evq_mem[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign cnt_o       = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + hrkd_pkg::EvqPtrW'(push_i);
    rd_ptr_d = rd_ptr_q + hrkd_pkg::EvqPtrW'(pop);
    cnt_d    = cnt_q + hrkd_pkg::EvqCntW'(push_i) - hrkd_pkg::EvqCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      evq_mem[wr_ptr_q] <= push_ev_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != hrkd_pkg::EvqCntW'(hrkd_pkg::EvqDepth)))
    else $error("event queue overflow");

  a_cnt_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[hrkd_pkg::EvqPtrW-1:0] == hrkd_pkg::EvqPtrW'(wr_ptr_q - rd_ptr_q))
    else $error("event queue count out of step with pointers");

endmodule

FILE: rtl/hid_report_key_event_diff.sv
// Boot keyboard report to key press/release events.
// Sequence: the accept cycle, then three passes of six slots
//   (press, release, unmark) at one read-modify-write of the status memory per cycle,
//   then a flush state for the pending word. A report is taken only in idle, with queue
//   room for all its words; the single status memory port sets this pace.
// Reset: a sweep over all 256 status memory entries clears them; no report is accepted meanwhile.
// Depends on hrkd_pkg and hrkd_evq.
module hid_report_key_event_diff (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] modifier_byte_i,
  input  logic [7:0] key_slot_0_i,
  input  logic [7:0] key_slot_1_i,
  input  logic [7:0] key_slot_2_i,
  input  logic [7:0] key_slot_3_i,
  input  logic [7:0] key_slot_4_i,
  input  logic [7:0] key_slot_5_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] event_keycode_o,
  output logic [7:0] event_modifiers_o,
  output logic       is_press_o,
  output logic       last_event_o
);

  localparam int KeyW  = hrkd_pkg::KeyW;
  localparam int SlotW = hrkd_pkg::SlotW;
  localparam int StW   = hrkd_pkg::StW;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_PRESS   = 6'b000100,
    ST_RELEASE = 6'b001000,
    ST_UNMARK  = 6'b010000,
    ST_FLUSH   = 6'b100000
  } state_e;

  // What the second stage does with the status it read.
  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_UNMARK  = 2'd2
  } op_e;

  state_e                 state_q, state_d;
  logic [SlotW-1:0]       slot_q, slot_d;
  logic [KeyW-1:0]        clr_addr_q, clr_addr_d;
  logic                   last_slot;
  logic                   accept;

  // Report being worked on and the one before it.
  logic [KeyW-1:0]        in_keys [hrkd_pkg::KeySlots];
  logic [KeyW-1:0]        cur_keys_q [hrkd_pkg::KeySlots];
  logic [KeyW-1:0]        cur_mods_q;
  logic [KeyW-1:0]        prev_keys_q [hrkd_pkg::KeySlots];
  logic [KeyW-1:0]        prev_mods_q;

  // Stage 1: address the status memory.
  logic                   issue;
  logic [KeyW-1:0]        rd_code;

  // Stage 2: modify and write back.
  logic                   s2_vld_q, s2_vld_d;
  op_e                    s2_op_q, s2_op_d;
  logic [KeyW-1:0]        s2_code_q;

  // Status memory and the bypass of the write made at the read's own edge.
  logic [StW-1:0]         status_mem [hrkd_pkg::KeycodeSpace];
  logic [StW-1:0]         rd_data_q;
  logic                   mem_we;
  logic [KeyW-1:0]        mem_wa;
  logic [StW-1:0]         mem_wd;
  logic                   fwd_vld_q;
  logic [KeyW-1:0]        fwd_addr_q;
  logic [StW-1:0]         fwd_data_q;
  logic [StW-1:0]         cur_st;

  // Newest event is held back until the next one, or the end, tells whether it is last.
  logic                   ev_vld;
  hrkd_pkg::event_t       ev;
  logic                   pend_vld_q, pend_vld_d;
  hrkd_pkg::event_t       pend_q, pend_d;
  logic                   push_vld;
  hrkd_pkg::event_t       push_ev;
  hrkd_pkg::event_t       out_ev;
  logic [hrkd_pkg::EvqCntW-1:0] evq_cnt;

  assign in_keys[0] = key_slot_0_i;
  assign in_keys[1] = key_slot_1_i;
  assign in_keys[2] = key_slot_2_i;
  assign in_keys[3] = key_slot_3_i;
  assign in_keys[4] = key_slot_4_i;
  assign in_keys[5] = key_slot_5_i;

  // Take a report only when the queue has room for every word it can cause.
  assign in_ready_o = (state_q == ST_IDLE) &&
                      (evq_cnt <= hrkd_pkg::EvqCntW'(hrkd_pkg::EvqDepth - hrkd_pkg::MaxEvents));
  assign accept     = in_valid_i && in_ready_o;
  assign last_slot  = (slot_q == SlotW'(hrkd_pkg::KeySlots - 1));

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    clr_addr_d = clr_addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == KeyW'(hrkd_pkg::KeycodeSpace - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        slot_d = '0;
        if (accept) begin
          state_d = ST_PRESS;
        end
      end
      ST_PRESS, ST_RELEASE, ST_UNMARK: begin
        slot_d = slot_q + 1'b1;
        if (last_slot) begin
          slot_d = '0;
          if (state_q == ST_PRESS) begin
            state_d = ST_RELEASE;
          end else if (state_q == ST_RELEASE) begin
            state_d = ST_UNMARK;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- stage 1
  // Release pass walks the previous report; the other two walk the current one.
  always_comb begin
    issue    = (state_q == ST_PRESS) || (state_q == ST_RELEASE) || (state_q == ST_UNMARK);
    rd_code  = (state_q == ST_RELEASE) ? prev_keys_q[slot_q] : cur_keys_q[slot_q];
    s2_vld_d = issue && (rd_code != '0);
    if (state_q == ST_PRESS) begin
      s2_op_d = OP_PRESS;
    end else if (state_q == ST_RELEASE) begin
      s2_op_d = OP_RELEASE;
    end else begin
      s2_op_d = OP_UNMARK;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    // The memory returns the old value when the previous write hit the same entry.
    cur_st = (fwd_vld_q && (fwd_addr_q == s2_code_q)) ? fwd_data_q : rd_data_q;

    mem_we = 1'b0;
    mem_wa = s2_code_q;
    mem_wd = cur_st;
    ev_vld = 1'b0;
    ev     = '{keycode: s2_code_q, modifiers: cur_mods_q, is_press: 1'b1, last: 1'b0};

    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = hrkd_pkg::StIdle;
    end else if (s2_vld_q) begin
      case (s2_op_q)
        OP_PRESS: begin
          mem_we = 1'b1;
          if (cur_st == hrkd_pkg::StIdle) begin
            mem_wd = hrkd_pkg::StHeld;
            ev_vld = 1'b1;
          end else begin
            mem_wd = cur_st | hrkd_pkg::StSeen;
          end
        end
        OP_RELEASE: begin
          // Held and not seen again: drop it.
          if (cur_st == hrkd_pkg::StHeld) begin
            mem_we       = 1'b1;
            mem_wd       = hrkd_pkg::StIdle;
            ev_vld       = 1'b1;
            ev.modifiers = prev_mods_q;
            ev.is_press  = 1'b0;
          end
        end
        OP_UNMARK: begin
          mem_we = 1'b1;
          mem_wd = cur_st & hrkd_pkg::StHeld;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // Hold back the newest event; push the older one, or flag the held one last.
  always_comb begin
    push_vld   = 1'b0;
    push_ev    = pend_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    if (ev_vld) begin
      push_vld   = pend_vld_q;
      pend_d     = ev;
      pend_vld_d = 1'b1;
    end else if ((state_q == ST_FLUSH) && pend_vld_q) begin
      push_vld     = 1'b1;
      push_ev.last = 1'b1;
      pend_vld_d   = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      slot_q      <= '0;
      clr_addr_q  <= '0;
      s2_vld_q    <= 1'b0;
      fwd_vld_q   <= 1'b0;
      pend_vld_q  <= 1'b0;
      prev_mods_q <= '0;
      for (int i = 0; i < hrkd_pkg::KeySlots; i++) begin
        prev_keys_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      clr_addr_q <= clr_addr_d;
      s2_vld_q   <= s2_vld_d;
      fwd_vld_q  <= mem_we;
      pend_vld_q <= pend_vld_d;
      // Advance the previous report once all passes are done.
      if (state_q == ST_FLUSH) begin
        prev_mods_q <= cur_mods_q;
        for (int i = 0; i < hrkd_pkg::KeySlots; i++) begin
          prev_keys_q[i] <= cur_keys_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q    <= s2_op_d;
    s2_code_q  <= rd_code;
    fwd_addr_q <= mem_wa;
    fwd_data_q <= mem_wd;
    pend_q     <= pend_d;
    if (accept) begin
      cur_mods_q <= modifier_byte_i;
      for (int i = 0; i < hrkd_pkg::KeySlots; i++) begin
        cur_keys_q[i] <= in_keys[i];
      end
    end
  end

  // Status memory with a registered read, read-before-write on a shared entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      status_mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= status_mem[rd_code];
  end

  // ---------------------------------------------------------------- output
  hrkd_evq u_evq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_vld),
    .push_ev_i   (push_ev),
    .cnt_o       (evq_cnt),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_ev_o    (out_ev)
  );

  assign event_keycode_o   = out_ev.keycode;
  assign event_modifiers_o = out_ev.modifiers;
  assign is_press_o        = out_ev.is_press;
  assign last_event_o      = out_ev.last;

  // ---------------------------------------------------------------- checks
  a_accept_starts_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_PRESS) && (slot_q == '0))
    else $error("accepted report did not start the press pass");

  a_idle_is_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!pend_vld_q && !s2_vld_q))
    else $error("work left in flight while idle");

  a_press_leaves_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && (s2_op_q == OP_PRESS)) |-> (mem_we && (mem_wd != hrkd_pkg::StIdle)))
    else $error("press pass left a key idle");

endmodule
